// ===== rtl/ctd_pkg.sv =====
// ----------------------------------------------------------------------------
// ctd_pkg: shared types and constants for the Cartesian tree depth unit
// Request formats, sequence storage sizes and command codes for the modules.
// ----------------------------------------------------------------------------
package ctd_pkg;

  // sequence storage
  localparam int MAX_LENGTH = 64;
  localparam int ADDR_W     = $clog2(MAX_LENGTH);
  localparam int LEN_W      = $clog2(MAX_LENGTH + 1);
  localparam int VALUE_W    = 7;
  localparam int DEPTH_W    = 6;

  // command codes from front to back
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_RUN   = 1'b1;

  // input request
  typedef struct packed {
    logic [6:0] element;
    logic       final_element;
  } item_t;

  // result request
  typedef struct packed {
    logic [5:0] tree_depth;
    logic       final_depth;
  } result_t;

  // classified command held in the front queue
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               kind;
  } cmd_t;

endpackage

// ===== rtl/cartesian_tree_depths_unit.sv =====
// ----------------------------------------------------------------------------
// cartesian_tree_depths_unit: max-rooted Cartesian tree node depths
// Loads a sequence one value per request, then returns each position's depth.
// ----------------------------------------------------------------------------
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   input    | push / full        | item   (element, final_element)
//   result   | pop / empty        | result (tree_depth, final_depth)
//
// The depth engine writes each store request into the value RAM as it takes
// it. A final request starts one scan per stored position, each reading every
// stored value through the single read port of the value RAM, so a sequence
// of length L yields L results. Reset (rst, synchronous) empties both queues
// and the store. Input requests queue while the engine scans; a full result
// queue stalls the start of the next scan.
// ----------------------------------------------------------------------------
module cartesian_tree_depths_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ctd_pkg::item_t   item,
  output logic             full,
  output logic             empty,
  input  logic             pop,
  output ctd_pkg::result_t result
);

  logic             cmd_valid;
  ctd_pkg::cmd_t    cmd;
  logic             cmd_pop;
  logic             res_push;
  ctd_pkg::result_t res;
  logic             res_full;

  ctd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  ctd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  ctd_out_queue u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (pop),
    .dout  (result),
    .empty (empty)
  );

endmodule

// ===== rtl/ctd_ram.sv =====
// ----------------------------------------------------------------------------
// ctd_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ctd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ctd_front.sv =====
// ----------------------------------------------------------------------------
// ctd_front: request intake
// Classifies each input request as store or store-and-run and queues it.
// ----------------------------------------------------------------------------
module ctd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ctd_pkg::item_t item,
  output logic          full,
  output logic          cmd_valid,
  output ctd_pkg::cmd_t cmd,
  input  logic          cmd_pop
);

  ctd_pkg::cmd_t slot [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    count;
  logic          do_push;
  logic          do_pop;
  ctd_pkg::cmd_t incoming;

  // classify the request
  always_comb begin
    incoming.value = item.element;
    incoming.kind  = item.final_element ? ctd_pkg::CMD_RUN : ctd_pkg::CMD_STORE;
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slot[rptr];
  assign do_push   = push & ~full;
  assign do_pop    = cmd_pop & cmd_valid;

  // two-entry command queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wptr] <= incoming;
    end
  end

endmodule

// ===== rtl/ctd_out_queue.sv =====
// ----------------------------------------------------------------------------
// ctd_out_queue: result queue
// Two-entry queue that decouples the depth engine from the result consumer.
// ----------------------------------------------------------------------------
module ctd_out_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ctd_pkg::result_t din,
  output logic             full,
  input  logic             pop,
  output ctd_pkg::result_t dout,
  output logic             empty
);

  ctd_pkg::result_t slot [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign dout    = slot[rptr];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wptr] <= din;
    end
  end

endmodule

// ===== rtl/ctd_back.sv =====
// ----------------------------------------------------------------------------
// ctd_back: depth engine
// Stores values, then for each position scans right and left through the
// value RAM with a running maximum, counting ancestors.
// ----------------------------------------------------------------------------
module ctd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  ctd_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output logic             res_push,
  output ctd_pkg::result_t res,
  input  logic             res_full
);

  // sequencer states
  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_WAIT  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  // scan step tags
  localparam logic [1:0] TAG_SELF  = 2'd0;
  localparam logic [1:0] TAG_RIGHT = 2'd1;
  localparam logic [1:0] TAG_LFIRST = 2'd2;
  localparam logic [1:0] TAG_LEFT  = 2'd3;

  localparam logic [ctd_pkg::LEN_W-1:0] FULL_COUNT = ctd_pkg::LEN_W'(ctd_pkg::MAX_LENGTH);

  logic [1:0]                    state;
  logic [1:0]                    state_next;
  logic [ctd_pkg::LEN_W-1:0]     loaded_count;
  logic [ctd_pkg::LEN_W-1:0]     loaded_count_next;
  logic [ctd_pkg::ADDR_W-1:0]    pos;
  logic [ctd_pkg::ADDR_W-1:0]    pos_next;
  logic [ctd_pkg::ADDR_W-1:0]    cur_addr;
  logic [ctd_pkg::ADDR_W-1:0]    cur_addr_next;
  logic [1:0]                    cur_tag;
  logic [1:0]                    cur_tag_next;

  // read pipeline tracking
  logic                          rd_valid;
  logic [1:0]                    rd_tag;
  logic                          rd_last;
  logic                          issue;
  logic                          issue_last;

  // running scan state
  logic [ctd_pkg::VALUE_W-1:0]   peak;
  logic [ctd_pkg::VALUE_W-1:0]   peak_next;
  logic [ctd_pkg::VALUE_W-1:0]   pval;
  logic [ctd_pkg::VALUE_W-1:0]   pval_next;
  logic [ctd_pkg::DEPTH_W-1:0]   cnt;
  logic [ctd_pkg::DEPTH_W-1:0]   cnt_next;

  logic                          we;
  logic [ctd_pkg::VALUE_W-1:0]   rdata;
  logic [ctd_pkg::VALUE_W-1:0]   vclamp;
  logic                          store_room;
  logic                          pos_is_last;
  logic                          right_more;

  assign store_room  = (loaded_count < FULL_COUNT);
  assign pos_is_last = (({1'b0, pos} + ctd_pkg::LEN_W'(1)) == loaded_count);
  assign right_more  = (({1'b0, cur_addr} + ctd_pkg::LEN_W'(1)) < loaded_count);

  // value store
  ctd_ram #(
    .WIDTH (ctd_pkg::VALUE_W),
    .DEPTH (ctd_pkg::MAX_LENGTH)
  ) u_values (
    .clk   (clk),
    .we    (we),
    .waddr (loaded_count[ctd_pkg::ADDR_W-1:0]),
    .wdata (cmd.value),
    .raddr (cur_addr),
    .rdata (rdata)
  );

  // sequencer: load, then one scan per position
  always_comb begin
    state_next        = state;
    loaded_count_next = loaded_count;
    pos_next          = pos;
    cur_addr_next     = cur_addr;
    cur_tag_next      = cur_tag;
    cmd_pop           = 1'b0;
    we                = 1'b0;
    issue             = 1'b0;
    issue_last        = 1'b0;
    unique case (state)
      S_LOAD: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (store_room) begin
            we                = 1'b1;
            loaded_count_next = loaded_count + ctd_pkg::LEN_W'(1);
          end
          if (cmd.kind == ctd_pkg::CMD_RUN) begin
            pos_next   = '0;
            state_next = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        if (!res_full) begin
          cur_addr_next = pos;
          cur_tag_next  = TAG_SELF;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        issue = 1'b1;
        if ((cur_tag == TAG_SELF || cur_tag == TAG_RIGHT) && right_more) begin
          cur_addr_next = cur_addr + ctd_pkg::ADDR_W'(1);
          cur_tag_next  = TAG_RIGHT;
        end else if ((cur_tag == TAG_SELF || cur_tag == TAG_RIGHT) && pos != '0) begin
          cur_addr_next = pos - ctd_pkg::ADDR_W'(1);
          cur_tag_next  = TAG_LFIRST;
        end else if ((cur_tag == TAG_LFIRST || cur_tag == TAG_LEFT) && cur_addr != '0) begin
          cur_addr_next = cur_addr - ctd_pkg::ADDR_W'(1);
          cur_tag_next  = TAG_LEFT;
        end else begin
          issue_last = 1'b1;
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        // last read is consumed this cycle
        if (pos_is_last) begin
          loaded_count_next = '0;
          state_next        = S_LOAD;
        end else begin
          pos_next   = pos + ctd_pkg::ADDR_W'(1);
          state_next = S_WAIT;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      loaded_count <= '0;
      rd_valid     <= 1'b0;
      rd_last      <= 1'b0;
    end else begin
      state        <= state_next;
      loaded_count <= loaded_count_next;
      rd_valid     <= issue;
      rd_last      <= issue_last;
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    cur_addr <= cur_addr_next;
    cur_tag  <= cur_tag_next;
    rd_tag   <= cur_tag;
    peak     <= peak_next;
    pval     <= pval_next;
    cnt      <= cnt_next;
  end

  // clamp values above the sequence length
  assign vclamp = (rdata > loaded_count) ? loaded_count : rdata;

  // running maximum and ancestor count
  always_comb begin
    peak_next = peak;
    pval_next = pval;
    cnt_next  = cnt;
    if (rd_valid) begin
      case (rd_tag) inside
        TAG_SELF: begin
          peak_next = vclamp;
          pval_next = vclamp;
          cnt_next  = '0;
        end
        TAG_LFIRST: begin
          if (vclamp > pval) begin
            peak_next = vclamp;
            cnt_next  = cnt + ctd_pkg::DEPTH_W'(1);
          end else begin
            peak_next = pval;
          end
        end
        TAG_RIGHT, TAG_LEFT: begin
          if (vclamp > peak) begin
            peak_next = vclamp;
            cnt_next  = cnt + ctd_pkg::DEPTH_W'(1);
          end
        end
        default: peak_next = peak;
      endcase
    end
  end

  // emit the depth when the scan of a position ends
  assign res_push        = rd_valid & rd_last;
  assign res.tree_depth  = cnt_next;
  assign res.final_depth = pos_is_last;

endmodule

// ===== verif/tb_cartesian_tree_depths_unit.sv =====
// ----------------------------------------------------------------------------
// tb_cartesian_tree_depths_unit: self-checking bench for the tree depth unit
// Streams sequences of element requests into the unit. A local predictor
// works out the max-rooted Cartesian tree depth of every stored position, and
// each returned result request is checked in order. Runs cover directed
// corners, random permutations, noise, repeated values, store overflow,
// random idling on both queues and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_cartesian_tree_depths_unit;

  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int PHASE_ITEMS    = 17;
  localparam int NUM_PHASES     = 4;
  // sender idle and receiver stall, percent of cycles, per phase
  localparam int SEND_IDLE[NUM_PHASES]  = '{0, 60, 0, 34};
  localparam int RECV_STALL[NUM_PHASES] = '{0, 0, 60, 34};

  typedef enum int {SEQ_PERMUTATION, SEQ_NOISE, SEQ_REPEATS} seq_kind_e;

  logic             clk  = 1'b0;
  logic             rst  = 1'b1;
  logic             push = 1'b0;
  ctd_pkg::item_t   item = '0;
  logic             pop  = 1'b0;
  logic             full;
  logic             empty;
  ctd_pkg::result_t result;

  ctd_pkg::item_t   pending_items[$];
  ctd_pkg::result_t expected_depths[$];
  logic [6:0]       build_values[$];

  // predictor state: the sequence loaded so far
  logic [6:0] loaded_values[ctd_pkg::MAX_LENGTH];
  int         loaded_len = 0;

  int error_count     = 0;
  int items_queued    = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_requests   = 0;
  int hold_served     = 0;
  int hold_left       = 0;
  int quiet_cycles    = 0;

  wire in_fire  = push && !full;
  wire out_fire = pop && !empty;

  cartesian_tree_depths_unit dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .item  (item),
    .full  (full),
    .empty (empty),
    .pop   (pop),
    .result(result)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    error_count++;
  endtask

  // ancestor count: larger values seen by a running peak, both directions
  function automatic int node_depth(input int pos, input int len,
                                    input logic [6:0] vals[ctd_pkg::MAX_LENGTH]);
    int         count;
    logic [6:0] peak;
    count = 0;
    peak = vals[pos];
    for (int j = pos + 1; j < len; j++) begin
      if (vals[j] > peak) begin
        count++;
        peak = vals[j];
      end
    end
    peak = vals[pos];
    for (int j = pos - 1; j >= 0; j--) begin
      if (vals[j] > peak) begin
        count++;
        peak = vals[j];
      end
    end
    return count;
  endfunction

  // fold one accepted request into the predictor
  task automatic absorb_element(input ctd_pkg::item_t req);
    logic [6:0]       clamped[ctd_pkg::MAX_LENGTH];
    ctd_pkg::result_t res;
    if (loaded_len < ctd_pkg::MAX_LENGTH) begin
      loaded_values[loaded_len] = req.element;
      loaded_len++;
    end
    if (req.final_element) begin
      for (int i = 0; i < ctd_pkg::MAX_LENGTH; i++)
        clamped[i] = (i < loaded_len && loaded_values[i] > loaded_len) ?
                     7'(loaded_len) : loaded_values[i];
      for (int i = 0; i < loaded_len; i++) begin
        res.tree_depth  = 6'(node_depth(i, loaded_len, clamped));
        res.final_depth = (i == loaded_len - 1);
        expected_depths = {expected_depths, res};
      end
      loaded_len = 0;
    end
  endtask

  // turn build_values into requests, final flag on the last one
  task automatic queue_sequence();
    ctd_pkg::item_t req;
    for (int i = 0; i < build_values.size(); i++) begin
      req.element       = build_values[i];
      req.final_element = (i == build_values.size() - 1);
      pending_items = {pending_items, req};
      items_queued++;
    end
  endtask

  // build_values becomes a shuffled permutation of 1..len
  task automatic make_permutation(input int len);
    logic [6:0] tmp;
    int         j;
    build_values.delete();
    for (int i = 1; i <= len; i++)
      build_values = {build_values, 7'(i)};
    for (int i = len - 1; i > 0; i--) begin
      j = $urandom_range(i, 0);
      tmp = build_values[i];
      build_values[i] = build_values[j];
      build_values[j] = tmp;
    end
  endtask

  task automatic queue_random_sequence();
    int        len;
    int        pick;
    seq_kind_e kind;
    pick = $urandom_range(99);
    kind = (pick < 75) ? SEQ_PERMUTATION : (pick < 87) ? SEQ_NOISE : SEQ_REPEATS;
    // mostly short sequences, the odd long one
    len = ($urandom_range(14) == 0) ? $urandom_range(ctd_pkg::MAX_LENGTH, 9) :
                                      $urandom_range(8, 1);
    make_permutation(len);
    case (kind)
      SEQ_NOISE: begin
        for (int i = 0; i < len; i++)
          build_values[i] = 7'($urandom_range(127, 0));
      end
      SEQ_REPEATS: begin
        for (int i = 0; i < len; i++)
          if ($urandom_range(2) == 0)
            build_values[i] = build_values[$urandom_range(len - 1, 0)];
      end
      default: ;
    endcase
    queue_sequence();
  endtask

  // driver: offer queued requests, hold each until it is taken
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (in_fire)
        absorb_element(item);
      if (!push || !full) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          item <= pending_items.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result request against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (out_fire) begin
        if (expected_depths.size() == 0) begin
          report_mismatch($sformatf("unexpected result depth=%0d final=%0b",
                                    result.tree_depth, result.final_depth));
        end else begin
          if (result.tree_depth !== expected_depths[0].tree_depth)
            report_mismatch($sformatf("tree_depth got %0d want %0d",
                                      result.tree_depth, expected_depths[0].tree_depth));
          if (result.final_depth !== expected_depths[0].final_depth)
            report_mismatch($sformatf("final_depth got %0b want %0b",
                                      result.final_depth, expected_depths[0].final_depth));
          void'(expected_depths.pop_front());
        end
      end
      // long hold-off when asked, otherwise random stalls
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (in_fire || out_fire) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus sequencing
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed corners
    build_values = '{7'd1};
    queue_sequence();
    build_values = '{7'd1, 7'd2, 7'd3, 7'd4};
    queue_sequence();
    build_values = '{7'd4, 7'd3, 7'd2, 7'd1};
    queue_sequence();
    build_values = '{7'd3, 7'd1, 7'd4, 7'd2, 7'd5};
    queue_sequence();
    // zero, all-ones and values above the length
    build_values = '{7'd127, 7'd0, 7'd64};
    queue_sequence();
    build_values = '{7'd2, 7'd2, 7'd2};
    queue_sequence();
    build_values = '{7'd5, 7'd1};
    queue_sequence();
    while (pending_items.size() != 0 || expected_depths.size() != 0)
      @(negedge clk);

    // random phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      sender_idle_pct = SEND_IDLE[p];
      recv_stall_pct  = RECV_STALL[p];
      items_queued = 0;
      while (items_queued < PHASE_ITEMS)
        queue_random_sequence();
      if (p == 0)
        hold_requests++;
      if (p == NUM_PHASES - 1) begin
        // exactly full store
        make_permutation(ctd_pkg::MAX_LENGTH);
        queue_sequence();
        // overflow: extra requests dropped, final one still runs the scan
        make_permutation(ctd_pkg::MAX_LENGTH);
        repeat ($urandom_range(3, 1))
          build_values = {build_values, 7'($urandom_range(127, 0))};
        queue_sequence();
      end
      while (pending_items.size() != 0)
        @(negedge clk);
    end

    // drain, then watch for stray results
    while (push || expected_depths.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
